>>> design/lsd_pkg.sv
`default_nettype none

package lsd_pkg;

  typedef struct packed {
    logic signed [15:0] accel_z;
    logic signed [15:0] tilt;
    logic signed [15:0] wheel_left;
    logic signed [15:0] wheel_right;
  } in_t;

  typedef struct packed {
    logic lifted;
    logic set_down;
    logic halted;
  } out_t;

  typedef enum logic [0:0] {
    CFG_BALANCE_REF,
    CFG_LIFT_THRESHOLD
  } cfg_reg_t;

  localparam int CFG_W = 15;
  localparam int MID_W = 14;
  localparam int THR_W = 15;

  localparam logic signed [MID_W-1:0] BALANCE_REF_RESET = '0;
  localparam logic [THR_W-1:0] LIFT_THRESHOLD_RESET = 15'd22000;

  localparam int TILT_LIFT_BAND  = 2000;
  localparam int TILT_DOWN_BAND  = 1000;
  localparam int STILL_SUM_LIMIT = 50;
  localparam int SPIN_LIMIT      = 50;
  localparam int NUDGE_LOW       = 3;
  localparam int NUDGE_HIGH      = 40;

endpackage

`default_nettype wire

>>> design/lift_and_set_down_detector.sv
// lift and set-down detector for a balancing car, one control tick per item
// result: registered from the accepted item, valid in the next cycle
// throughput: one item per cycle unless stalled; all per-tick work is one pass of
// compares and counter updates between the accepted item and the result register
// reset (rst, synchronous): detectors idle, stop flag clear, registers to defaults
`default_nettype none

module lift_and_set_down_detector #(
  parameter int STILL_TICKS  = 10,
  parameter int SPIKE_WINDOW = 200,
  parameter int SPIN_WINDOW  = 100
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire lsd_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output lsd_pkg::out_t                    out_data,
  input  wire logic                        cfg_we,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [lsd_pkg::CFG_W-1:0]   cfg_data
);

  localparam int STILL_W = $clog2(STILL_TICKS + 1);
  localparam int SPIKE_W = $clog2(SPIKE_WINDOW + 1);
  localparam int SPIN_W  = $clog2(SPIN_WINDOW + 1);

  localparam logic [STILL_W-1:0] STILL_LIM = STILL_W'(STILL_TICKS);
  localparam logic [SPIKE_W-1:0] SPIKE_LIM = SPIKE_W'(SPIKE_WINDOW);
  localparam logic [SPIN_W-1:0]  SPIN_LIM  = SPIN_W'(SPIN_WINDOW);

  typedef enum logic [1:0] {
    PH_STILL,
    PH_SPIKE,
    PH_SPIN
  } phase_t;

  // configuration
  logic signed [lsd_pkg::MID_W-1:0] balance_ref;
  logic [lsd_pkg::THR_W-1:0]        lift_threshold;

  // detector state
  phase_t               phase, phase_next;
  logic [STILL_W-1:0]   still_count, still_count_next;
  logic [SPIKE_W-1:0]   spike_count, spike_count_next;
  logic [SPIN_W-1:0]    spin_count, spin_count_next;
  logic                 down_armed, down_armed_next;
  logic                 stop_state, stop_state_next;
  logic                 lifted_next, set_down_next;

  logic                 accept;

  // per-tick tests
  logic signed [16:0] wl_x, wr_x, tilt_diff;
  logic [16:0]        abs_l, abs_r;
  logic [17:0]        still_sum;
  logic signed [17:0] spin_sum;
  logic [17:0]        spin_abs;
  logic               still_ok, spike_ok, spin_ok, down_ok, nudge_ok;
  logic               nudge_l, nudge_r;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    wl_x      = {in_data.wheel_left[15], in_data.wheel_left};
    wr_x      = {in_data.wheel_right[15], in_data.wheel_right};
    abs_l     = wl_x[16] ? 17'(-wl_x) : wl_x;
    abs_r     = wr_x[16] ? 17'(-wr_x) : wr_x;
    still_sum = {1'b0, abs_l} + {1'b0, abs_r};
    still_ok  = still_sum < 18'(lsd_pkg::STILL_SUM_LIMIT);

    spin_sum  = {wl_x[16], wl_x} + {wr_x[16], wr_x};
    spin_abs  = spin_sum[17] ? 18'(-spin_sum) : spin_sum;
    spin_ok   = spin_abs > 18'(lsd_pkg::SPIN_LIMIT);

    tilt_diff = {in_data.tilt[15], in_data.tilt} - {{3{balance_ref[13]}}, balance_ref};

    // positive accel only can beat an unsigned 15-bit threshold
    spike_ok  = !in_data.accel_z[15] && (in_data.accel_z[14:0] > lift_threshold) &&
                (tilt_diff > 17'(-lsd_pkg::TILT_LIFT_BAND)) &&
                (tilt_diff < 17'(lsd_pkg::TILT_LIFT_BAND));

    down_ok   = (tilt_diff > 17'(-lsd_pkg::TILT_DOWN_BAND)) &&
                (tilt_diff < 17'(lsd_pkg::TILT_DOWN_BAND)) &&
                (in_data.wheel_left == '0) && (in_data.wheel_right == '0);

    nudge_l   = !in_data.wheel_left[15] &&
                (in_data.wheel_left[14:0] > 15'(lsd_pkg::NUDGE_LOW)) &&
                (in_data.wheel_left[14:0] < 15'(lsd_pkg::NUDGE_HIGH));
    nudge_r   = !in_data.wheel_right[15] &&
                (in_data.wheel_right[14:0] > 15'(lsd_pkg::NUDGE_LOW)) &&
                (in_data.wheel_right[14:0] < 15'(lsd_pkg::NUDGE_HIGH));
    nudge_ok  = nudge_l || nudge_r;
  end

  // phases fall through in order within one tick
  always_comb begin
    phase_next       = phase;
    still_count_next = still_count;
    spike_count_next = spike_count;
    spin_count_next  = spin_count;
    down_armed_next  = down_armed;
    stop_state_next  = stop_state;
    lifted_next      = 1'b0;
    set_down_next    = 1'b0;

    if (phase_next == PH_STILL) begin
      if (still_ok) begin
        if (still_count_next >= STILL_LIM) begin
          still_count_next = '0;
          phase_next       = PH_SPIKE;
        end else begin
          still_count_next = still_count_next + 1'b1;
        end
      end else begin
        still_count_next = '0;
      end
    end

    if (phase_next == PH_SPIKE) begin
      if (spike_count_next >= SPIKE_LIM) begin
        spike_count_next = '0;
        phase_next       = PH_STILL;
      end else begin
        spike_count_next = spike_count_next + 1'b1;
      end
      // a spike still wins on the tick the window runs out
      if (spike_ok) begin
        phase_next = PH_SPIN;
      end
    end

    if (phase_next == PH_SPIN) begin
      if (spin_count_next >= SPIN_LIM) begin
        spin_count_next = '0;
        phase_next      = PH_STILL;
      end else begin
        spin_count_next = spin_count_next + 1'b1;
      end
      if (spin_ok) begin
        phase_next      = PH_STILL;
        lifted_next     = 1'b1;
        stop_state_next = 1'b1;
      end
    end

    if (stop_state_next) begin
      if (!down_armed_next && down_ok) begin
        down_armed_next = 1'b1;
      end
      if (down_armed_next && nudge_ok) begin
        down_armed_next = 1'b0;
        set_down_next   = 1'b1;
        stop_state_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      balance_ref    <= lsd_pkg::BALANCE_REF_RESET;
      lift_threshold <= lsd_pkg::LIFT_THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lsd_pkg::CFG_BALANCE_REF:    balance_ref    <= cfg_data[lsd_pkg::MID_W-1:0];
        lsd_pkg::CFG_LIFT_THRESHOLD: lift_threshold <= cfg_data[lsd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_STILL;
      still_count <= '0;
      spike_count <= '0;
      spin_count  <= '0;
      down_armed  <= 1'b0;
      stop_state  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        still_count <= still_count_next;
        spike_count <= spike_count_next;
        spin_count  <= spin_count_next;
        down_armed  <= down_armed_next;
        stop_state  <= stop_state_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.lifted   <= lifted_next;
      out_data.set_down <= set_down_next;
      out_data.halted   <= stop_state_next;
    end
  end

`ifndef ASSERT_OFF
  a_armed_only_stopped: assert property (@(posedge clk) disable iff (rst)
    down_armed |-> stop_state)
    else $error("set-down armed while running");

  a_setdown_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.set_down) |-> !out_data.halted)
    else $error("set-down item left stop flag set");

  a_lift_halts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.lifted && !out_data.set_down) |-> out_data.halted)
    else $error("lift item without stop flag");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid && out_data.halted == stop_state))
    else $error("accepted item gave no matching result");

  a_still_bound: assert property (@(posedge clk) disable iff (rst)
    still_count <= STILL_LIM)
    else $error("still counter past limit");
`endif

endmodule

`default_nettype wire

>>> bench/tb_lift_and_set_down_detector.sv
module tb_lift_and_set_down_detector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STILL_TICKS  = 10;
  localparam int SPIKE_WINDOW = 200;
  localparam int SPIN_WINDOW  = 100;

  localparam int LIFT_BAND   = 2000;
  localparam int DOWN_BAND   = 1000;
  localparam int STILL_SUM   = 50;
  localparam int SPIN_SUM    = 50;
  localparam int NUDGE_MIN   = 3;
  localparam int NUDGE_MAX   = 40;

  localparam int PHASE_TICKS = 230;
  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    int   az;
    int   tilt;
    int   wl;
    int   wr;
    bit   typed;
    lsd_pkg::out_t want;
  } row_t;

  // directed ticks at reset settings: centre 0, threshold 22000
  localparam row_t PLAN [23] = '{
    '{-32768, -18000, -32768, -32768, 1'b1, 3'b000},
    '{ 32767,  18000,  32767,  32767, 1'b1, 3'b000},
    '{     0,      0,     25,     25, 1'b0, 3'b000},
    '{-32768, -18000,    -24,     25, 1'b0, 3'b000},
    '{ 32767,  18000,     49,      0, 1'b0, 3'b000},
    '{     0,      0,      0,    -49, 1'b0, 3'b000},
    '{   100,   5000,     12,    -12, 1'b0, 3'b000},
    '{ -5000,  -1500,      0,      0, 1'b0, 3'b000},
    '{ 30000,   1500,      1,      1, 1'b0, 3'b000},
    '{     0,      0,      0,      0, 1'b0, 3'b000},
    '{ 22001,  -2000,     -3,      3, 1'b0, 3'b000},
    '{    -1,     -1,      0,      0, 1'b0, 3'b000},
    '{     7,      7,      0,      0, 1'b0, 3'b000},
    // still count runs out here: spike window opens, tilt on the band edge
    '{ 22001,   2000,      0,      0, 1'b0, 3'b000},
    '{ 22000,      0,      0,      0, 1'b0, 3'b000},
    '{ 22001,   1999,     -1,      1, 1'b0, 3'b000},
    '{     0,      0,    -25,    -25, 1'b0, 3'b000},
    '{     0,      0,    -26,    -25, 1'b1, 3'b101},
    '{     0,  -1000,      0,      0, 1'b0, 3'b000},
    '{     0,    999,      0,      0, 1'b0, 3'b000},
    '{     0,      0,      3,     40, 1'b0, 3'b000},
    '{     0,      0,     -5,     39, 1'b1, 3'b010},
    '{    -1,      0,      0,      0, 1'b0, 3'b000}
  };

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  lsd_pkg::in_t              in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  lsd_pkg::out_t             out_data;
  logic                      cfg_we = 1'b0;
  logic [0:0]                cfg_index = '0;
  logic [lsd_pkg::CFG_W-1:0] cfg_data = '0;

  lift_and_set_down_detector #(
    .STILL_TICKS(STILL_TICKS),
    .SPIKE_WINDOW(SPIKE_WINDOW),
    .SPIN_WINDOW(SPIN_WINDOW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // detector state as the block should hold it
  logic signed [13:0] mid_cfg = '0;
  logic [14:0]        thr_cfg = 15'd22000;
  logic [1:0]         lift_phase = '0;
  logic [3:0]         still_cnt = '0;
  logic [7:0]         spike_cnt = '0;
  logic [6:0]         spin_cnt = '0;
  logic               down_armed = 1'b0;
  logic               stopped = 1'b0;

  lsd_pkg::out_t pending_reports[$];
  lsd_pkg::in_t  tick_q[$];
  int   bad_reports = 0;
  bit   no_gaps = 1'b0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic lsd_pkg::out_t advance_detector(input lsd_pkg::in_t t);
    int   az, tl, wl, wr, mid, quiet, spin;
    lsd_pkg::out_t r;
    az = t.accel_z;
    tl = t.tilt;
    wl = t.wheel_left;
    wr = t.wheel_right;
    mid = mid_cfg;
    quiet = ((wl < 0) ? -wl : wl) + ((wr < 0) ? -wr : wr);
    spin = wl + wr;
    if (spin < 0) spin = -spin;
    r = '0;
    if (lift_phase == 2'd0) begin
      if (quiet < STILL_SUM) begin
        if (still_cnt >= STILL_TICKS) begin
          still_cnt = '0;
          lift_phase = 2'd1;
        end else begin
          still_cnt = still_cnt + 4'd1;
        end
      end else begin
        still_cnt = '0;
      end
    end
    if (lift_phase == 2'd1) begin
      if (spike_cnt >= SPIKE_WINDOW) begin
        spike_cnt = '0;
        lift_phase = 2'd0;
      end else begin
        spike_cnt = spike_cnt + 8'd1;
      end
      // a spike wins over the window running out in the same tick
      if (az > int'(thr_cfg) && tl > mid - LIFT_BAND && tl < mid + LIFT_BAND)
        lift_phase = 2'd2;
    end
    if (lift_phase == 2'd2) begin
      if (spin_cnt >= SPIN_WINDOW) begin
        spin_cnt = '0;
        lift_phase = 2'd0;
      end else begin
        spin_cnt = spin_cnt + 7'd1;
      end
      if (spin > SPIN_SUM) begin
        lift_phase = 2'd0;
        r.lifted = 1'b1;
        stopped = 1'b1;
      end
    end
    if (stopped) begin
      if (!down_armed && tl > mid - DOWN_BAND && tl < mid + DOWN_BAND && wl == 0 && wr == 0)
        down_armed = 1'b1;
      if (down_armed && ((wl > NUDGE_MIN && wl < NUDGE_MAX) ||
                         (wr > NUDGE_MIN && wr < NUDGE_MAX))) begin
        down_armed = 1'b0;
        r.set_down = 1'b1;
        stopped = 1'b0;
      end
    end
    r.halted = stopped;
    return r;
  endfunction

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic bit coin();
    return $urandom_range(1) == 1;
  endfunction

  function automatic int rnd16();
    return span(-32768, 32767);
  endfunction

  function automatic int rnd_tilt();
    return span(-18000, 18000);
  endfunction

  // wheel delta that never counts as a forward nudge
  function automatic int dud();
    return coin() ? span(-40, NUDGE_MIN) : span(NUDGE_MAX, 60);
  endfunction

  function automatic lsd_pkg::in_t mk(input int az, input int tl, input int wl, input int wr);
    lsd_pkg::in_t t;
    t.accel_z = 16'(az);
    t.tilt = 16'(tl);
    t.wheel_left = 16'(wl);
    t.wheel_right = 16'(wr);
    return t;
  endfunction

  function automatic lsd_pkg::in_t noise_tick();
    return mk(rnd16(), rnd_tilt(), rnd16(), rnd16());
  endfunction

  // a lift and set-down attempt (still run, spike, spin, arm, nudge) or noise
  task automatic plan_episode();
    int mid, thr, a, b, n, wl, s;
    mid = mid_cfg;
    thr = thr_cfg;
    if ($urandom_range(99) < 12) begin
      repeat (span(1, 6)) tick_q.push_back(noise_tick());
      return;
    end
    n = span(8, 13);
    repeat (n) begin
      a = span(0, 49);
      b = span(0, 49 - a);
      if ($urandom_range(99) < 6) b = span(50 - a, 200);
      tick_q.push_back(mk(rnd16(), rnd_tilt(), coin() ? -a : a, coin() ? -b : b));
    end
    n = ($urandom_range(99) < 5) ? span(150, 260) : span(0, 8);
    repeat (n) tick_q.push_back(noise_tick());
    if ($urandom_range(99) < 85 && thr < 32767)
      tick_q.push_back(mk(span(thr + 1, 32767), mid + span(-1999, 1999),
                          coin() ? rnd16() : 0, 0));
    n = ($urandom_range(99) < 5) ? span(90, 130) : span(0, 6);
    repeat (n) begin
      wl = span(-30000, 30000);
      tick_q.push_back(mk(rnd16(), rnd_tilt(), wl, span(-SPIN_SUM, SPIN_SUM) - wl));
    end
    if ($urandom_range(99) < 85) begin
      s = span(SPIN_SUM + 1, 400);
      wl = span(-20000, 20000);
      tick_q.push_back(mk(rnd16(), rnd_tilt(), wl, (coin() ? -s : s) - wl));
    end
    repeat (span(0, 4)) tick_q.push_back(mk(rnd16(), rnd_tilt(), span(-3, 3), span(-3, 3)));
    if ($urandom_range(99) < 80)
      tick_q.push_back(mk(rnd16(), mid + span(-999, 999), 0, 0));
    repeat (span(0, 3)) tick_q.push_back(mk(rnd16(), rnd_tilt(), dud(), dud()));
    if ($urandom_range(99) < 85) begin
      if (coin())
        tick_q.push_back(mk(rnd16(), rnd_tilt(), span(NUDGE_MIN + 1, NUDGE_MAX - 1), dud()));
      else
        tick_q.push_back(mk(rnd16(), rnd_tilt(), dud(), span(NUDGE_MIN + 1, NUDGE_MAX - 1)));
    end
  endtask

  task automatic send(input lsd_pkg::in_t t, input bit typed, input lsd_pkg::out_t want);
    lsd_pkg::out_t guess;
    while (!no_gaps && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = advance_detector(t);
    pending_reports.push_back(typed ? want : guess);
  endtask

  // only called with in_valid low; waits for the block to drain first
  task automatic program_regs(input int mid, input int thr);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= lsd_pkg::CFG_BALANCE_REF;
    cfg_data <= lsd_pkg::CFG_W'(mid);
    @(posedge clk);
    cfg_index <= lsd_pkg::CFG_LIFT_THRESHOLD;
    cfg_data <= lsd_pkg::CFG_W'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    mid_cfg = 14'(mid);
    thr_cfg = 15'(thr);
  endtask

  always @(posedge clk) begin : collect
    lsd_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        bad_reports++;
        if (bad_reports <= 10) $display("unexpected report %b", out_data);
      end else begin
        want = pending_reports.pop_front();
        if (out_data.lifted !== want.lifted || out_data.set_down !== want.set_down ||
            out_data.halted !== want.halted) begin
          bad_reports++;
          if (bad_reports <= 10)
            $display("report mismatch: lifted %b/%b set_down %b/%b halted %b/%b (exp/got)",
                     want.lifted, out_data.lifted, want.set_down, out_data.set_down,
                     want.halted, out_data.halted);
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rst || calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 28);
    end
  end

  // ends the run when nothing moves on either side for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle = 0;
      else
        idle++;
    end
    $display("lift_and_set_down_detector test failed");
    $finish;
  end

  initial begin : main
    int sent;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (PLAN[i])
      send(mk(PLAN[i].az, PLAN[i].tilt, PLAN[i].wl, PLAN[i].wr), PLAN[i].typed, PLAN[i].want);
    for (int p = 0; p < 5; p++) begin
      in_valid <= 1'b0;
      case (p)
        0: program_regs(-4500, 0);
        1: program_regs(4500, 32767);
        2: program_regs(span(-4500, 4500), span(0, 30000));
        3: program_regs(span(-4500, 4500), 22000);
        default: program_regs(0, span(0, 32767));
      endcase
      tick_q.delete();
      calm = (p == 3);
      no_gaps = calm;
      sent = 0;
      while (sent < PHASE_TICKS) begin
        // receiver holds off while items keep coming, so the block backs up
        if (p == 2 && sent == 60) begin
          hold_req = 1'b1;
          no_gaps = 1'b1;
        end
        if (p == 2 && sent == 110) no_gaps = 1'b0;
        if (tick_q.size() == 0) plan_episode();
        send(tick_q.pop_front(), 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (bad_reports == 0 && pending_reports.size() == 0)
      $display("lift_and_set_down_detector test passed");
    else
      $display("lift_and_set_down_detector test failed");
    $finish;
  end

endmodule
